[hw/rtl/quaternion_arithmetic_unit_assert.svh]
// Assertion macros used by the quaternion unit checker.
// Expects signals named clk and rst in the scope of use.
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/qau_pkg.sv]
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies.
`default_nettype none

package qau_pkg;

  localparam int Q_W = 16;

  // Mode codes on the mode input.
  localparam logic [1:0] MODE_MUL  = 2'd0;
  localparam logic [1:0] MODE_ROT  = 2'd1;
  localparam logic [1:0] MODE_CONJ = 2'd2;
  localparam logic [1:0] MODE_MAG  = 2'd3;

  // Queue between front and back.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;
  localparam int FQ_CW    = 3;

  // Result queue.
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = 1;
  localparam int OQ_CW    = 2;

  typedef logic signed [Q_W-1:0] fix_t;
  typedef logic signed [2*Q_W-1:0] prod_t;
  typedef prod_t prod_arr_t [4][4];

  typedef struct packed {
    fix_t w;
    fix_t x;
    fix_t y;
    fix_t z;
  } quat_t;

  // Operation class decoded by the front part.
  typedef struct packed {
    logic rot;
    logic mag;
    logic cnj;
  } op_t;

  typedef struct packed {
    op_t   op;
    quat_t a;
    quat_t b;
  } item_t;

  typedef struct packed {
    quat_t q;
    logic  sat;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit on signed Q3.12 words (FRAC_BITS fraction bits). Each input
// transaction carries a mode and two quaternions a and b and yields exactly one result:
// mode 0 the Hamilton product a*b, mode 1 the rotation a*b*conj(a), mode 2 conj(a), mode 3
// the squared magnitude of a in r_w with r_x, r_y, r_z zero. Every quaternion product is
// summed at full width, rounded to nearest with ties toward plus infinity, and clipped to
// 16 bits; any clip, including one in the rotation's intermediate product or in negating
// the most negative value, raises saturated. The unit takes one transaction per clock while
// full is low; each transaction passes through the four-entry input queue, four pipeline
// stages (multiply, round, multiply, round), then the two-entry result queue on its way to
// the output ports. All modes pass through the same stages, so results leave in push order.
// full rises only when the input queue holds four transactions; the pipeline holds still
// whenever its last stage has a result and the result queue is full.
// Depends on qau_pkg, qau_front, qau_back and qau_outq.
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] b_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] r_w,
  output logic signed [15:0] r_x,
  output logic signed [15:0] r_y,
  output logic signed [15:0] r_z,
  output logic               saturated
);
  import qau_pkg::*;

  item_t raw;
  item_t head;
  logic  head_valid;
  logic  take;
  logic  res_wr;
  logic  res_full;
  res_t  res_in;
  res_t  res_out;

  // Bundle the operand ports; the front fills in the operation class.
  always_comb begin
    raw.op = '0;
    raw.a  = {a_w, a_x, a_y, a_z};
    raw.b  = {b_w, b_x, b_y, b_z};
  end

  qau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .mode       (mode),
    .raw        (raw),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  qau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (head_valid),
    .in_item  (head),
    .in_take  (take),
    .out_full (res_full),
    .out_wr   (res_wr),
    .out_res  (res_in)
  );

  qau_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .empty   (empty),
    .pop     (pop),
    .rd_data (res_out)
  );

  // Drive the result ports from the head of the result queue.
  assign r_w       = res_out.q.w;
  assign r_x       = res_out.q.x;
  assign r_y       = res_out.q.y;
  assign r_z       = res_out.q.z;
  assign saturated = res_out.sat;

endmodule

`default_nettype wire

[hw/rtl/qau_front.sv]
// Front part: accepts input transactions, decodes the mode and queues them.
// Depends on qau_pkg.
`default_nettype none

module qau_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     mode,
  input  qau_pkg::item_t raw,
  output logic           full,
  output logic           head_valid,
  output qau_pkg::item_t head,
  input  logic           take
);
  import qau_pkg::*;

  item_t            mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_CW-1:0] count;
  logic             wr;
  logic             rd;
  item_t            cls;

  // Decode the mode; magnitude mode multiplies a by itself.
  always_comb begin
    cls      = raw;
    cls.op   = '0;
    unique case (mode)
      MODE_MUL:  cls.op = '0;
      MODE_ROT:  cls.op.rot = 1'b1;
      MODE_CONJ: cls.op.cnj = 1'b1;
      MODE_MAG: begin
        cls.op.mag = 1'b1;
        cls.b      = raw.a;
      end
    endcase
  end

  assign full       = (count == FQ_CW'(FQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign wr         = push && !full;
  assign rd         = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= cls;
  end

endmodule

`default_nettype wire

[hw/rtl/qau_back.sv]
// Back part: four-stage pipeline of two Hamilton products with rounding.
// Depends on qau_pkg.
`default_nettype none

module qau_back #(
  parameter int FRAC_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qau_pkg::item_t in_item,
  output logic           in_take,
  input  logic           out_full,
  output logic           out_wr,
  output qau_pkg::res_t  out_res
);
  import qau_pkg::*;

  localparam logic signed [34:0] HALF = 35'sd1 <<< (FRAC_BITS - 1);

  // Signed sum of one Hamilton component; mag gives the sum of squares.
  function automatic logic signed [33:0] hsum(input prod_arr_t p, input logic [1:0] k,
                                              input logic mag);
    logic signed [33:0] s;
    s = '0;
    case (k)
      2'd0: begin
        if (mag) s = 34'(p[0][0]) + 34'(p[1][1]) + 34'(p[2][2]) + 34'(p[3][3]);
        else     s = 34'(p[0][0]) - 34'(p[1][1]) - 34'(p[2][2]) - 34'(p[3][3]);
      end
      2'd1: s = 34'(p[0][1]) + 34'(p[1][0]) + 34'(p[2][3]) - 34'(p[3][2]);
      2'd2: s = 34'(p[0][2]) - 34'(p[1][3]) + 34'(p[2][0]) + 34'(p[3][1]);
      default: s = 34'(p[0][3]) + 34'(p[1][2]) - 34'(p[2][1]) + 34'(p[3][0]);
    endcase
    return s;
  endfunction

  // Round half up, then clip; bit 16 is the clip flag.
  function automatic logic [16:0] rnd_sat(input logic signed [33:0] v);
    logic signed [34:0] s;
    logic signed [34:0] sh;
    logic [16:0]        r;
    s  = 35'(v) + HALF;
    sh = s >>> FRAC_BITS;
    if (sh > 35'sd32767)       r = {1'b1, 16'h7fff};
    else if (sh < -35'sd32768) r = {1'b1, 16'h8000};
    else                       r = {1'b0, sh[15:0]};
    return r;
  endfunction

  logic      adv;

  logic      s1_valid;
  op_t       s1_op;
  fix_t      s1_a [4];
  prod_arr_t s1_p;

  logic      s2_valid;
  op_t       s2_op;
  fix_t      s2_t [4];
  fix_t      s2_c [4];
  logic      s2_flag;

  logic      s3_valid;
  logic      s3_rot;
  fix_t      s3_t [4];
  prod_arr_t s3_p;
  logic      s3_flag;

  logic      s4_valid;
  res_t      s4_res;

  fix_t      ia [4];
  fix_t      ib [4];
  fix_t      t1 [4];
  fix_t      c1 [4];
  logic [3:0] ft;
  logic [3:0] fc;
  fix_t      s2_t_next [4];
  logic      s2_flag_next;
  logic [16:0] rs1 [4];
  logic signed [16:0] neg [4];
  logic [16:0] rs2 [4];
  res_t      s4_res_next;
  logic [3:0] f2;

  // Stall every stage together when the finished result cannot leave.
  assign adv     = !(s4_valid && out_full);
  assign in_take = in_valid && adv;
  assign out_wr  = s4_valid && !out_full;
  assign out_res = s4_res;

  always_comb begin
    ia[0] = in_item.a.w; ia[1] = in_item.a.x; ia[2] = in_item.a.y; ia[3] = in_item.a.z;
    ib[0] = in_item.b.w; ib[1] = in_item.b.x; ib[2] = in_item.b.y; ib[3] = in_item.b.z;
  end

  // Stage 2: round the first product, form conj(a), pick the class result.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs1[k] = rnd_sat(hsum(s1_p, 2'(k), s1_op.mag));
      t1[k]  = rs1[k][15:0];
      ft[k]  = rs1[k][16];
      neg[k] = -17'(s1_a[k]);
    end
    c1[0] = s1_a[0];
    fc[0] = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (neg[k] > 17'sd32767) begin
        c1[k] = 16'sh7fff;
        fc[k] = 1'b1;
      end else begin
        c1[k] = neg[k][15:0];
        fc[k] = 1'b0;
      end
    end
    for (int k = 0; k < 4; k++) s2_t_next[k] = t1[k];
    s2_flag_next = |ft;
    if (s1_op.cnj) begin
      for (int k = 0; k < 4; k++) s2_t_next[k] = c1[k];
      s2_flag_next = |fc;
    end else if (s1_op.mag) begin
      for (int k = 1; k < 4; k++) s2_t_next[k] = '0;
      s2_flag_next = ft[0];
    end else if (s1_op.rot) begin
      s2_flag_next = (|ft) || (|fc);
    end
  end

  // Stage 4: round the second product for rotation, else pass through.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs2[k] = rnd_sat(hsum(s3_p, 2'(k), 1'b0));
      f2[k]  = rs2[k][16];
    end
    if (s3_rot) begin
      s4_res_next.q   = {rs2[0][15:0], rs2[1][15:0], rs2[2][15:0], rs2[3][15:0]};
      s4_res_next.sat = s3_flag || (|f2);
    end else begin
      s4_res_next.q   = {s3_t[0], s3_t[1], s3_t[2], s3_t[3]};
      s4_res_next.sat = s3_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= in_item.op;
      for (int i = 0; i < 4; i++) begin
        s1_a[i] <= ia[i];
        for (int j = 0; j < 4; j++) s1_p[i][j] <= ia[i] * ib[j];
      end
      s2_op   <= s1_op;
      s2_flag <= s2_flag_next;
      for (int i = 0; i < 4; i++) begin
        s2_t[i] <= s2_t_next[i];
        s2_c[i] <= c1[i];
      end
      s3_rot  <= s2_op.rot;
      s3_flag <= s2_flag;
      for (int i = 0; i < 4; i++) begin
        s3_t[i] <= s2_t[i];
        for (int j = 0; j < 4; j++) s3_p[i][j] <= s2_t[i] * s2_c[j];
      end
      s4_res <= s4_res_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/qau_outq.sv]
// Result queue in front of the output ports.
// Depends on qau_pkg.
`default_nettype none

module qau_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  qau_pkg::res_t wr_data,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output qau_pkg::res_t rd_data
);
  import qau_pkg::*;

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic             rd;

  assign full    = (count == OQ_CW'(OQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];
  assign rd      = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

[hw/rtl/qau_checker.sv]
// Port-level checker for the quaternion arithmetic unit, bound to the top level.
// Depends on quaternion_arithmetic_unit_assert.svh.
`default_nettype none

`include "quaternion_arithmetic_unit_assert.svh"

module qau_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic signed [15:0] r_w,
  input logic               saturated
);

  // Reset leaves both queues empty.
  `QAU_ASSERT_ALWAYS(a_reset_clear, rst |=> (empty && !full), "queues not clear after reset")

  // The input queue fills only through accepted pushes.
  `QAU_ASSERT(a_full_needs_push, $rose(full) |-> $past(push), "full rose without a push")

  // A waiting result holds until it is popped.
  `QAU_ASSERT(a_hold_result, (!empty && !pop) |=> (!empty && $stable(r_w) && $stable(saturated)), "result changed while waiting")

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .r_w       (r_w),
  .saturated (saturated)
);

`default_nettype wire
